### rtl/cbq_pkg.sv
// shared constants, types and rounding helper for the cascaded biquad filter
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 20;
  localparam int COEF_FRAC    = COEF_WIDTH - 4;
  localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W        = PROD_W + 4;
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int ACT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int SLOT_W       = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SECTIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE    = 1'd1;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd1;
  localparam logic signed [COEF_WIDTH-1:0] SCALE_RESET =
    COEF_WIDTH'(1 << COEF_FRAC);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } ctrl_state_t;

  typedef struct packed {
    logic                          en;
    logic [SLOT_W-1:0]             slot;
    logic signed [COEF_WIDTH-1:0]  value;
  } coef_wr_t;

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] smax;
    logic signed [ACC_W-1:0] smin;
    smax = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    smin = -smax - ACC_W'(1);
    r = a + (ACC_W'(1) <<< (COEF_FRAC - 1));
    q = r >>> COEF_FRAC;
    if (q > smax) begin
      round_sat = smax[SAMPLE_WIDTH-1:0];
    end else if (q < smin) begin
      round_sat = smin[SAMPLE_WIDTH-1:0];
    end else begin
      round_sat = q[SAMPLE_WIDTH-1:0];
    end
  endfunction

endpackage

### rtl/cascaded_biquad_iir_filter.sv
// top level of the cascaded direct-form-1 biquad filter
`timescale 1ns / 1ps

// A filter beat runs through a row of biquad cells, one section after the other; each cell
// uses its own multiplier. The active section count is clamped to 1..MAX_SECTIONS. A
// coefficient write beat stores the word and clears that section's history. The next beat
// is taken only after the previous sample has moved into the output register, which may
// still wait on out_ready.

module cascaded_biquad_iir_filter
  import cbq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic [IDX_W-1:0]               section_index,
  input  logic [SLOT_W-1:0]              coef_slot,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic [ACT_W-1:0]             active_sections;
  logic signed [COEF_WIDTH-1:0] output_scale;
  logic [SEC_W-1:0]             last_sec;
  logic                         accept;
  logic                         start0;
  logic                         scale_start;
  logic                         scale_done;
  logic signed [SAMPLE_WIDTH-1:0] scale_v;

  logic                           cell_start [MAX_SECTIONS];
  logic                           cell_done  [MAX_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] cell_x     [MAX_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] cell_y     [MAX_SECTIONS];
  coef_wr_t                       cell_wr    [MAX_SECTIONS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign start0    = accept && (cmd == CMD_FILTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= ACTIVE_RESET;
      output_scale    <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_SECTIONS: active_sections <= cfg_data[ACT_W-1:0];
        REG_OUTPUT_SCALE:    output_scale    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(active_sections) == 0) begin
      last_sec = '0;
    end else if (int'(active_sections) > MAX_SECTIONS) begin
      last_sec = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_sec = SEC_W'(int'(active_sections) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start0) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (scale_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  for (genvar s = 0; s < MAX_SECTIONS; s++) begin : g_cell
    if (s == 0) begin : g_first
      assign cell_start[s] = start0;
      assign cell_x[s]     = sample_in;
    end else begin : g_rest
      assign cell_start[s] = cell_done[s-1] && (int'(last_sec) >= s);
      assign cell_x[s]     = cell_y[s-1];
    end

    assign cell_wr[s].en    = accept && (cmd == CMD_WRITE) &&
                              (int'(section_index) == s);
    assign cell_wr[s].slot  = coef_slot;
    assign cell_wr[s].value = coef_value;

    cbq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .start (cell_start[s]),
      .x_in  (cell_x[s]),
      .wr    (cell_wr[s]),
      .done  (cell_done[s]),
      .y_out (cell_y[s])
    );
  end

  always_comb begin
    scale_start = 1'b0;
    scale_v     = cell_y[0];
    for (int s = 0; s < MAX_SECTIONS; s++) begin
      if (int'(last_sec) == s) begin
        scale_start = cell_done[s];
        scale_v     = cell_y[s];
      end
    end
  end

  cbq_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .start     (scale_start),
    .v_in      (scale_v),
    .scale     (output_scale),
    .done      (scale_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (filtered_out)
  );

endmodule

### rtl/cbq_cell.sv
// one biquad section: coefficients, history and a multiply-accumulate sequencer
`timescale 1ns / 1ps

module cbq_cell
  import cbq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  coef_wr_t                       wr,
  output logic                           done,
  output logic signed [SAMPLE_WIDTH-1:0] y_out
);

  logic signed [COEF_WIDTH-1:0]   coef [4];
  logic signed [SAMPLE_WIDTH-1:0] hist [4];
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic [2:0]                     phase;
  logic                           busy;
  logic signed [SAMPLE_WIDTH-1:0] y_next;

  assign y_next = round_sat(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
      for (int k = 0; k < 4; k++) begin
        coef[k] <= '0;
        hist[k] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (wr.en) begin
        coef[wr.slot] <= wr.value;
        for (int k = 0; k < 4; k++) begin
          hist[k] <= '0;
        end
      end
      if (start && !busy) begin
        x_reg <= x_in;
        acc   <= ACC_W'(x_in) <<< COEF_FRAC;
        phase <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase <= 3'd3) begin
          prod <= coef[phase[1:0]] * hist[phase[1:0]];
        end
        if (phase == 3'd1 || phase == 3'd2) begin
          acc <= acc + ACC_W'(prod);
        end else if (phase == 3'd3 || phase == 3'd4) begin
          acc <= acc - ACC_W'(prod);
        end
        if (phase == 3'd5) begin
          hist[1] <= hist[0];
          hist[0] <= x_reg;
          hist[3] <= hist[2];
          hist[2] <= y_next;
          y_out   <= y_next;
          done    <= 1'b1;
          busy    <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/cbq_scaler.sv
// output gain, rounding, saturation and result register
`timescale 1ns / 1ps

module cbq_scaler
  import cbq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] v_in,
  input  logic signed [COEF_WIDTH-1:0]   scale,
  output logic                           done,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_data
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     move;

  assign move = prod_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= move;
      if (start) begin
        prod       <= v_in * scale;
        prod_valid <= 1'b1;
      end else if (move) begin
        prod_valid <= 1'b0;
      end
      if (move) begin
        out_data  <= round_sat(ACC_W'(prod));
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
